@@ hw/rtl/pbd_pkg.sv @@
package pbd_pkg;

   // Default fraction width of sample and threshold values.
   localparam int FRAC_BITS_DEF = 16;

   // Field widths.
   localparam int SAMPLE_W = 33;
   localparam int TIME_W   = 32;
   localparam int RATE_W   = 8;
   localparam int COUNT_W  = 32;
   localparam int THR_W    = 32;
   localparam int REG16_W  = 16;
   localparam int REG24_W  = 24;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_W = ((SAMPLE_W + TIME_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RATE_W + COUNT_W + 7) / 8) * 8;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = REG24_W;

   // Shared serial unit: a 32-bit operand, a 16-bit operand, 16 steps.
   localparam int OPA_W = 32;
   localparam int OPB_W = 16;
   localparam int ACC_W = OPA_W + OPB_W;
   localparam int STEPS = OPB_W;

   // Register reset values.
   localparam logic [REG16_W-1:0] INIT_HOLDOFF_RST = 16'd2000;
   localparam logic [REG16_W-1:0] MASK_HOLDOFF_RST = 16'd500;
   localparam logic [REG24_W-1:0] MIN_THR_RST      = 24'd13107;
   localparam logic [REG24_W-1:0] MAX_THR_RST      = 24'd851968;
   localparam logic [REG16_W-1:0] DECAY_STEP_RST   = 16'd131;
   localparam logic [REG16_W-1:0] RECOV_STEP_RST   = 16'd33;
   localparam logic [REG16_W-1:0] CAND_FRAC_RST    = 16'd1311;
   localparam logic [REG16_W-1:0] MAX_INTERVAL_RST = 16'd2000;

   localparam logic [TIME_W-1:0] MIN_INTERVAL_MS = 32'd300;
   localparam logic [OPB_W-1:0]  MS_PER_MINUTE   = 16'd60000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_INIT_HOLDOFF = 3'd0,
      CSR_MASK_HOLDOFF = 3'd1,
      CSR_MIN_THR      = 3'd2,
      CSR_MAX_THR      = 3'd3,
      CSR_DECAY_STEP   = 3'd4,
      CSR_RECOV_STEP   = 3'd5,
      CSR_CAND_FRAC    = 3'd6,
      CSR_MAX_INTERVAL = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [REG16_W-1:0] init_holdoff;
      logic [REG16_W-1:0] mask_holdoff;
      logic [REG24_W-1:0] min_thr;
      logic [REG24_W-1:0] max_thr;
      logic [REG16_W-1:0] decay_step;
      logic [REG16_W-1:0] recov_step;
      logic [REG16_W-1:0] cand_frac;
      logic [REG16_W-1:0] max_interval;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_MUL = 2'b01,
      OP_DIV = 2'b10
   } unit_op_type;

   typedef struct packed {
      logic              start;
      unit_op_type       op;
      logic [OPA_W-1:0]  opa;
      logic [OPB_W-1:0]  opb;
   } unit_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [ACC_W-1:0]  result;
   } unit_rsp_type;

endpackage

@@ hw/rtl/pbd_csr.sv @@
module pbd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [pbd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [pbd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output pbd_pkg::cfg_type                  cfg
);
   import pbd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_INIT_HOLDOFF: cfg_in.init_holdoff = csr_wdata[REG16_W-1:0];
            CSR_MASK_HOLDOFF: cfg_in.mask_holdoff = csr_wdata[REG16_W-1:0];
            CSR_MIN_THR:      cfg_in.min_thr      = csr_wdata[REG24_W-1:0];
            CSR_MAX_THR:      cfg_in.max_thr      = csr_wdata[REG24_W-1:0];
            CSR_DECAY_STEP:   cfg_in.decay_step   = csr_wdata[REG16_W-1:0];
            CSR_RECOV_STEP:   cfg_in.recov_step   = csr_wdata[REG16_W-1:0];
            CSR_CAND_FRAC:    cfg_in.cand_frac    = csr_wdata[REG16_W-1:0];
            CSR_MAX_INTERVAL: cfg_in.max_interval = csr_wdata[REG16_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_holdoff <= INIT_HOLDOFF_RST;
         cfg_ff.mask_holdoff <= MASK_HOLDOFF_RST;
         cfg_ff.min_thr      <= MIN_THR_RST;
         cfg_ff.max_thr      <= MAX_THR_RST;
         cfg_ff.decay_step   <= DECAY_STEP_RST;
         cfg_ff.recov_step   <= RECOV_STEP_RST;
         cfg_ff.cand_frac    <= CAND_FRAC_RST;
         cfg_ff.max_interval <= MAX_INTERVAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/pbd_serial_unit.sv @@
module pbd_serial_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  pbd_pkg::unit_req_type   req,
   output pbd_pkg::unit_rsp_type   rsp
);
   import pbd_pkg::*;

   localparam int CNT_W = $clog2(STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   unit_op_type       op_ff, op_in;
   logic [OPA_W-1:0]  opa_ff, opa_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [OPB_W-1:0]  sh_ff, sh_in;

   logic [ACC_W-1:0]  add_a, add_b;
   logic              add_cin;
   logic [ACC_W:0]    sum;
   logic [OPB_W:0]    rem_sh;
   logic              no_borrow;

   // One adder serves both operations. Multiply is shift and add, MSB of
   // the multiplier first; divide is restoring, one quotient bit a step.
   always_comb begin
      rem_sh = {acc_ff[OPB_W-1:0], sh_ff[OPB_W-1]};
      if (op_ff == OP_DIV) begin
         add_a   = ACC_W'(rem_sh);
         add_b   = ~ACC_W'(opa_ff[OPB_W-1:0]);
         add_cin = 1'b1;
      end else begin
         add_a   = {acc_ff[ACC_W-2:0], 1'b0};
         add_b   = sh_ff[OPB_W-1] ? ACC_W'(opa_ff) : '0;
         add_cin = 1'b0;
      end
      sum       = {1'b0, add_a} + {1'b0, add_b} + (ACC_W+1)'(add_cin);
      no_borrow = sum[ACC_W];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      opa_in  = opa_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         op_in   = req.op;
         opa_in  = req.opa;
         acc_in  = '0;
         sh_in   = req.opb;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (op_ff == OP_DIV) begin
            acc_in = no_borrow ? sum[ACC_W-1:0] : add_a;
            sh_in  = {sh_ff[OPB_W-2:0], no_borrow};
         end else begin
            acc_in = sum[ACC_W-1:0];
            sh_in  = {sh_ff[OPB_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= OP_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff <= opa_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
   end

   assign rsp.busy   = busy_ff;
   assign rsp.done   = done_ff;
   assign rsp.result = (op_ff == OP_DIV) ? ACC_W'(sh_ff) : acc_ff;

endmodule

@@ hw/rtl/pbd_core.sv @@
module pbd_core #(
   parameter int FRAC_BITS = pbd_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pbd_pkg::cfg_type                  cfg,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pbd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pbd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [0:0]                        rsp_tuser,
   output pbd_pkg::unit_req_type             unit_req,
   input  pbd_pkg::unit_rsp_type             unit_rsp
);
   import pbd_pkg::*;

   // The confirmation margin is the Q0.16 fraction rescaled to FRAC_BITS.
   localparam int SH_UP    = (FRAC_BITS >= OPB_W) ? FRAC_BITS - OPB_W : 0;
   localparam int SH_DN    = (FRAC_BITS >= OPB_W) ? 0 : OPB_W - FRAC_BITS;
   localparam int MARGIN_W = OPB_W + SH_UP;
   localparam int SUM_W    = (MARGIN_W + 2 > SAMPLE_W + 2) ? MARGIN_W + 2 : SAMPLE_W + 2;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EVAL = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } seq_state_type;

   typedef enum logic [4:0] {
      PH_INIT  = 5'b00001,
      PH_WAIT  = 5'b00010,
      PH_SLOPE = 5'b00100,
      PH_MAYBE = 5'b01000,
      PH_MASK  = 5'b10000
   } phase_type;

   seq_state_type             st_ff, st_in;
   phase_type                 phase_ff, phase_in;
   logic [THR_W-1:0]          thr_ff, thr_in;
   logic [RATE_W-1:0]         rate_ff, rate_in;
   logic [TIME_W-1:0]         last_ff, last_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic                      det_ff, det_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [TIME_W-1:0]         now_ff, now_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                      rsp_det_ff, rsp_det_in;

   logic                      accept, out_load;
   logic signed [SUM_W-1:0]   s_x, thr_x, min_x, max_x, decay_x, recov_x, margin_x;
   logic signed [SUM_W-1:0]   t_step, t_lo, t_clamp;
   logic [MARGIN_W-1:0]       margin;
   logic [TIME_W-1:0]         interval;
   logic [THR_W-1:0]          prod_q;
   logic                      s_pos, confirm, rate_ok, mask_done;
   logic                      start_mul, start_div;

   assign req_tready = (st_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_load   = (st_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   // Datapath for the threshold, the margin test and the beat interval.
   always_comb begin
      s_x      = SUM_W'(sample_ff);
      thr_x    = $signed(SUM_W'(thr_ff));
      min_x    = $signed(SUM_W'(cfg.min_thr));
      max_x    = $signed(SUM_W'(cfg.max_thr));
      decay_x  = $signed(SUM_W'(cfg.decay_step));
      recov_x  = $signed(SUM_W'(cfg.recov_step));
      margin   = (MARGIN_W'(cfg.cand_frac) << SH_UP) >> SH_DN;
      margin_x = $signed(SUM_W'(margin));

      // Minimum clamp first, maximum last, so the maximum wins when crossed.
      t_step   = (s_x > min_x) ? thr_x - decay_x : thr_x + recov_x;
      t_lo     = (t_step < min_x) ? min_x : t_step;
      t_clamp  = (t_lo > max_x) ? max_x : t_lo;

      s_pos     = !sample_ff[SAMPLE_W-1] && (sample_ff != '0);
      confirm   = (s_x + margin_x) < thr_x;
      interval  = now_ff - last_ff;
      rate_ok   = (last_ff != '0) && (interval > MIN_INTERVAL_MS)
                  && (interval < TIME_W'(cfg.max_interval));
      mask_done = interval > TIME_W'(cfg.mask_holdoff);
      prod_q    = unit_rsp.result[ACC_W-1:OPB_W];

      start_mul = (st_ff == ST_EVAL) && (phase_ff == PH_SLOPE) && s_pos;
      start_div = (st_ff == ST_EVAL) && (phase_ff == PH_MAYBE) && confirm && rate_ok;
   end

   always_comb begin
      unit_req.start = start_mul || start_div;
      unit_req.op    = start_div ? OP_DIV : OP_MUL;
      unit_req.opa   = start_div ? OPA_W'(interval[OPB_W-1:0])
                                 : OPA_W'(sample_ff[OPA_W-1:0]);
      unit_req.opb   = start_div ? MS_PER_MINUTE : cfg.cand_frac;
   end

   always_comb begin
      st_in        = st_ff;
      phase_in     = phase_ff;
      thr_in       = thr_ff;
      rate_in      = rate_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      det_in       = det_ff;
      sample_in    = sample_ff;
      now_in       = now_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_det_in   = rsp_det_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = $signed(req_tdata[SAMPLE_W-1:0]);
               now_in    = req_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
               det_in    = 1'b0;
               st_in     = ST_EVAL;
               // A restart puts the detector back to its initial state
               // before this beat is evaluated.
               if (req_tuser[0]) begin
                  phase_in = PH_INIT;
                  thr_in   = THR_W'(cfg.max_thr);
                  rate_in  = '0;
                  last_in  = '0;
                  count_in = '0;
               end
            end
         end
         ST_EVAL: begin
            st_in = ST_OUT;
            case (phase_ff)
               PH_INIT: begin
                  if (now_ff > TIME_W'(cfg.init_holdoff)) begin
                     phase_in = PH_WAIT;
                  end
               end
               PH_WAIT: begin
                  if (s_x > thr_x) begin
                     phase_in = PH_SLOPE;
                  end
                  thr_in = t_clamp[THR_W-1:0];
               end
               PH_SLOPE: begin
                  if (s_x < thr_x) begin
                     phase_in = PH_MAYBE;
                  end
                  if (s_pos) begin
                     st_in = ST_MUL;
                  end else begin
                     thr_in = THR_W'(cfg.min_thr);
                  end
               end
               PH_MAYBE: begin
                  if (confirm) begin
                     det_in   = 1'b1;
                     last_in  = now_ff;
                     count_in = count_ff + 1'b1;
                     phase_in = PH_MASK;
                     if (rate_ok) begin
                        st_in = ST_DIV;
                     end
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end
               PH_MASK: begin
                  if (mask_done) begin
                     phase_in = PH_WAIT;
                  end
               end
               default: phase_in = PH_INIT;
            endcase
         end
         ST_MUL: begin
            if (unit_rsp.done) begin
               thr_in = (prod_q < THR_W'(cfg.min_thr)) ? THR_W'(cfg.min_thr) : prod_q;
               st_in  = ST_OUT;
            end
         end
         ST_DIV: begin
            if (unit_rsp.done) begin
               rate_in = unit_rsp.result[RATE_W-1:0];
               st_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({count_ff, rate_ff});
               rsp_det_in   = det_ff;
               st_in        = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         phase_ff     <= PH_INIT;
         thr_ff       <= THR_W'(MAX_THR_RST);
         rate_ff      <= '0;
         last_ff      <= '0;
         count_ff     <= '0;
         det_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         phase_ff     <= phase_in;
         thr_ff       <= thr_in;
         rate_ff      <= rate_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         det_ff       <= det_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      now_ff      <= now_in;
      rsp_data_ff <= rsp_data_in;
      rsp_det_ff  <= rsp_det_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_det_ff;

   // The shared unit is only started from the evaluation step.
   a_start_in_eval: assert property (@(posedge clock) disable iff (reset)
      unit_req.start |-> (st_ff == ST_EVAL))
      else $error("serial unit started outside evaluation");

   // A finished operation is only reported while the sequencer waits for it.
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      unit_rsp.done |-> (st_ff == ST_MUL || st_ff == ST_DIV))
      else $error("serial unit finished while sequencer was not waiting");

   // The interval floor keeps the rate below two hundred.
   a_rate_bound: assert property (@(posedge clock) disable iff (reset)
      rate_ff <= RATE_W'(199))
      else $error("beat rate out of range");

   // A result is loaded only from the output step, and the sequencer then idles.
   a_load_to_idle: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (st_ff == ST_IDLE) && rsp_valid_ff)
      else $error("output load did not return sequencer to idle");

endmodule

@@ hw/rtl/pulse_beat_detector_top.sv @@
// Adaptive-threshold pulse beat detector for a filtered AC photoplethysmogram.
// Input stream req_*: one beat per sample carries the signed sample and a
// millisecond timestamp in req_tdata, and a restart flag in req_tuser that
// puts the detector back to its initial state before that sample is used.
// Output stream rsp_*: exactly one beat per input beat, with the beat flag in
// rsp_tuser and the latest rate and the running beat count in rsp_tdata.
// The csr_* port writes one tuning register per clock; the user must write
// only while the block idles, and the block itself does not enforce this.
// In the common case a sample passes from idle through evaluation to the
// output step. When a sample is evaluated in slope following with a positive
// value, or confirms a beat whose interval lies in the allowed window, the
// shared serial unit runs sixteen shift-and-add or restore-and-subtract steps
// while the sequencer waits for it before the output step.
// req_tready is high only while the sequencer is idle, one sample at a time.
// The result sits in an output register, so the next sample is accepted while
// the previous result still waits; if the receiver stalls, the sequencer
// holds its finished result until that register frees up.
// Synchronous reset restores every tuning register to its default, clears the
// detector state and drops rsp_tvalid; no clearing pass is needed.
module pulse_beat_detector_top #(
   parameter int FRAC_BITS = pbd_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration writes.
   input  logic                              csr_we,
   input  logic [pbd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [pbd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // Sample stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pbd_pkg::REQ_DATA_W-1:0]    req_tdata,  // sample[32:0], now_ms[64:33], pad
   input  logic [0:0]                        req_tuser,  // restart[0]
   // Result stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pbd_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // beat_rate[7:0], beats_seen[39:8]
   output logic [0:0]                        rsp_tuser   // beat_flag[0]
);
   import pbd_pkg::*;

   cfg_type       cfg;
   unit_req_type  unit_req;
   unit_rsp_type  unit_rsp;

   // Tuning registers.
   pbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Shared multiply and divide unit.
   pbd_serial_unit u_unit (
      .clock (clock),
      .reset (reset),
      .req   (unit_req),
      .rsp   (unit_rsp)
   );

   // Phase machine, threshold datapath and output register.
   pbd_core #(
      .FRAC_BITS (FRAC_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .unit_req   (unit_req),
      .unit_rsp   (unit_rsp)
   );

endmodule
